@@ hdl/euler_rotate_point_core_macros.svh @@
// Assertion helpers shared by the modules of the point rotator.
// Both expect the enclosing module to have clk and an active-low rst_n.
`ifndef EULER_ROTATE_POINT_CORE_MACROS_SVH
`define EULER_ROTATE_POINT_CORE_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ERP_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define ERP_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ hdl/erp_pkg.sv @@
package erp_pkg;

    // Angle codes and the sine table.  ANGLE_STEPS is a power of two, so the
    // code taken modulo the step count is simply its low ANGLE_BITS bits.
    localparam int ANGLE_CODE_BITS = 10;
    localparam int ANGLE_STEPS     = 1024;
    localparam int ANGLE_BITS      = $clog2(ANGLE_STEPS);

    localparam int COORD_BITS     = 24;
    localparam int TRIG_BITS      = 16;
    localparam int COEF_BITS      = 18;
    localparam int COEF_FRAC_BITS = 15;
    localparam int COEF_COUNT     = 9;

    typedef logic [ANGLE_CODE_BITS-1:0]        angle_t;
    typedef logic [ANGLE_BITS-1:0]             rom_addr_t;
    typedef logic signed [COORD_BITS-1:0]      coord_t;
    typedef logic signed [TRIG_BITS-1:0]       trig_t;
    typedef logic signed [COEF_BITS-1:0]       coef_t;
    typedef coef_t                             coef_set_t [COEF_COUNT];
    typedef trig_t                             sine_rom_t [ANGLE_STEPS];

    // Configuration register indexes.
    typedef logic [1:0] cfg_index_t;
    localparam cfg_index_t CFG_ANGLE_X = 2'd0;
    localparam cfg_index_t CFG_ANGLE_Y = 2'd1;
    localparam cfg_index_t CFG_ANGLE_Z = 2'd2;

    localparam longint unsigned TWO_PI_Q29 = 64'd3373259426;
    localparam longint unsigned ONE_Q30    = 64'd1073741824;
    localparam longint unsigned HALF_Q30   = 64'h2000_0000;
    localparam longint unsigned FULL_Q30   = 64'h4000_0000;

    // Rounds a Q30 value to nearest Q15, magnitude first, clamped to 32767.
    function automatic longint q30_to_q15(input longint v);
        longint mag;
        longint r;
        mag = (v < 0) ? -v : v;
        r = (mag + 64'sd16384) >>> 15;
        if (r > 64'sd32767)
            r = 64'sd32767;
        return (v < 0) ? -r : r;
    endfunction

    function automatic longint unsigned taylor_term(input longint unsigned t,
                                                    input longint unsigned a2);
        return (t * a2) >> 30;
    endfunction

    // Builds the Q1.15 sine table at elaboration.  Each angle is folded into
    // the first octant, where a Taylor series in Q30 gives sine and cosine.
    function automatic sine_rom_t sine_table();
        sine_rom_t tab;
        longint unsigned p;
        longint unsigned r;
        longint unsigned a;
        longint unsigned a2;
        longint unsigned t;
        longint sn;
        longint cs;
        longint s;
        longint c;
        longint fs;
        int unsigned q;
        for (int k = 0; k < ANGLE_STEPS; k++)
        begin
            p = (64'(k) << 32) / ANGLE_STEPS;
            q = 32'((p >> 30) & 64'd3);
            r = p & 64'h3FFF_FFFF;
            if (r <= HALF_Q30)
                a = (r * TWO_PI_Q29) >> 31;
            else
                a = ((FULL_Q30 - r) * TWO_PI_Q29) >> 31;
            a2 = (a * a) >> 30;

            t  = a;
            sn = a;
            t = taylor_term(t, a2) / 6;   sn = sn - t;
            t = taylor_term(t, a2) / 20;  sn = sn + t;
            t = taylor_term(t, a2) / 42;  sn = sn - t;
            t = taylor_term(t, a2) / 72;  sn = sn + t;
            t = taylor_term(t, a2) / 110; sn = sn - t;
            t = taylor_term(t, a2) / 156; sn = sn + t;

            t  = ONE_Q30;
            cs = ONE_Q30;
            t = taylor_term(t, a2) / 2;   cs = cs - t;
            t = taylor_term(t, a2) / 12;  cs = cs + t;
            t = taylor_term(t, a2) / 30;  cs = cs - t;
            t = taylor_term(t, a2) / 56;  cs = cs + t;
            t = taylor_term(t, a2) / 90;  cs = cs - t;
            t = taylor_term(t, a2) / 132; cs = cs + t;

            if (r <= HALF_Q30)
            begin
                s = sn;
                c = cs;
            end
            else
            begin
                s = cs;
                c = sn;
            end
            case (q)
                0:       fs = s;
                1:       fs = c;
                2:       fs = -s;
                default: fs = -c;
            endcase
            tab[k] = TRIG_BITS'(q30_to_q15(fs));
        end
        return tab;
    endfunction

endpackage

@@ hdl/euler_rotate_point_core.sv @@
// Channel  Handshake              Word
// -------  ---------------------  -------------------------------------------
// in       in_valid / in_ready    in_x, in_y, in_z (Q16.8), in_last
// out      out_valid / out_ready  out_x, out_y, out_z (Q16.8, saturated), out_last
// cfg      cfg_valid / cfg_ready  cfg_index, cfg_data (angle code)
//
// One point word is taken every cycle unless the output stalls, a configuration
// write is offered or the matrix is rebuilt; each result passes through the
// four register stages of the datapath.  After reset and after every
// configuration write the coefficient unit rebuilds the matrix (it reads the
// six sines and cosines from the table, then runs eleven multiply steps),
// during which in_ready and cfg_ready are low.
// A stall on the output fills the pipeline's empty stages first, so a point
// is still taken while a finished word waits.
module euler_rotate_point_core
    import erp_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,

    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  cfg_index_t cfg_index,
    input  angle_t     cfg_data,

    input  logic       in_valid,
    output logic       in_ready,
    input  coord_t     in_x,
    input  coord_t     in_y,
    input  coord_t     in_z,
    input  logic       in_last,

    output logic       out_valid,
    input  logic       out_ready,
    output coord_t     out_x,
    output coord_t     out_y,
    output coord_t     out_z,
    output logic       out_last
);

    // The three angle registers, all zero after reset.
    angle_t    angle_x_reg, angle_y_reg, angle_z_reg;
    logic      cfg_we;
    logic      coef_busy;
    coef_set_t coef;

    // A write is refused while the matrix is being rebuilt.  Writes to an
    // index beyond the three angles are taken and leave the angles alone.
    assign cfg_ready = !coef_busy;
    assign cfg_we    = cfg_valid && cfg_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            angle_x_reg <= '0;
            angle_y_reg <= '0;
            angle_z_reg <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_ANGLE_X: angle_x_reg <= cfg_data;
                CFG_ANGLE_Y: angle_y_reg <= cfg_data;
                CFG_ANGLE_Z: angle_z_reg <= cfg_data;
                default:     ;
            endcase
        end
    end

    // The coefficient unit turns the angles into the nine Q2.15 matrix
    // entries with one shared set of multipliers over several cycles.
    erp_coef_unit u_coef (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg_we  (cfg_we),
        .angle_x (angle_x_reg),
        .angle_y (angle_y_reg),
        .angle_z (angle_z_reg),
        .coef    (coef),
        .busy    (coef_busy)
    );

    // Points are held back while the matrix is rebuilt, and also in the
    // cycle of a configuration write so that the write takes effect first.
    erp_datapath u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .hold      (coef_busy || cfg_valid),
        .coef      (coef),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_x      (in_x),
        .in_y      (in_y),
        .in_z      (in_z),
        .in_last   (in_last),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_x     (out_x),
        .out_y     (out_y),
        .out_z     (out_z),
        .out_last  (out_last)
    );

endmodule

@@ hdl/erp_coef_unit.sv @@
`include "euler_rotate_point_core_macros.svh"

module erp_coef_unit
    import erp_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      cfg_we,
    input  angle_t    angle_x,
    input  angle_t    angle_y,
    input  angle_t    angle_z,
    output coef_set_t coef,
    output logic      busy
);

    typedef enum logic [2:0] {
        ST_IDLE  = 3'b001,
        ST_FETCH = 3'b010,
        ST_MULT  = 3'b100
    } coef_state_t;

    typedef logic [3:0]                   step_t;
    typedef logic signed [2*TRIG_BITS-1:0] pair_t;
    typedef logic signed [3*TRIG_BITS-1:0] triple_t;

    localparam sine_rom_t SINE_ROM   = sine_table();
    localparam rom_addr_t QUARTER    = rom_addr_t'(ANGLE_STEPS / 4);
    localparam step_t     FETCH_LAST = step_t'(6);
    localparam step_t     LAST_COEF  = step_t'(COEF_COUNT - 1);
    localparam step_t     MULT_LAST  = step_t'(COEF_COUNT + 1);
    localparam step_t     NEG_S2_IDX = step_t'(7);
    localparam triple_t   ROUND_HALF = triple_t'(1) <<< (2 * COEF_FRAC_BITS - 1);

    coef_state_t state_reg, state_next;
    step_t       cnt_reg, cnt_next;

    rom_addr_t rom_addr;
    trig_t     rom_q_reg;
    trig_t     s1_reg, c1_reg, s2_reg, c2_reg, s3_reg, c3_reg;

    trig_t   op_x, op_y, op_z, op_v, op_w;
    logic    op_neg;
    logic    a_v_reg, b_v_reg;
    pair_t   a_p1_reg, a_p2_reg;
    trig_t   a_z_reg;
    logic    a_neg_reg, b_neg_reg;
    step_t   a_idx_reg, b_idx_reg;
    triple_t b_t_reg;
    pair_t   b_d_reg;
    triple_t coef_sum;
    triple_t coef_rnd;
    coef_t   coef_reg [COEF_COUNT];

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (cfg_we)
                begin
                    state_next = ST_FETCH;
                    cnt_next   = '0;
                end
            end
            ST_FETCH:
            begin
                if (cnt_reg == FETCH_LAST)
                begin
                    state_next = ST_MULT;
                    cnt_next   = '0;
                end
                else
                    cnt_next = cnt_reg + step_t'(1);
            end
            ST_MULT:
            begin
                if (cnt_reg == MULT_LAST)
                begin
                    state_next = ST_IDLE;
                    cnt_next   = '0;
                end
                else
                    cnt_next = cnt_reg + step_t'(1);
            end
            default:
            begin
                state_next = ST_IDLE;
                cnt_next   = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_FETCH;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    // Six reads of the sine table; cosine is the sine a quarter turn on.
    always_comb
    begin
        unique case (cnt_reg)
            4'd0:    rom_addr = rom_addr_t'(angle_x);
            4'd1:    rom_addr = rom_addr_t'(angle_x) + QUARTER;
            4'd2:    rom_addr = rom_addr_t'(angle_y);
            4'd3:    rom_addr = rom_addr_t'(angle_y) + QUARTER;
            4'd4:    rom_addr = rom_addr_t'(angle_z);
            4'd5:    rom_addr = rom_addr_t'(angle_z) + QUARTER;
            default: rom_addr = rom_addr_t'(angle_x);
        endcase
    end

    always_ff @(posedge clk)
    begin
        rom_q_reg <= SINE_ROM[rom_addr];
        if (state_reg == ST_FETCH)
        begin
            unique case (cnt_reg)
                4'd1:    s1_reg <= rom_q_reg;
                4'd2:    c1_reg <= rom_q_reg;
                4'd3:    s2_reg <= rom_q_reg;
                4'd4:    c2_reg <= rom_q_reg;
                4'd5:    s3_reg <= rom_q_reg;
                4'd6:    c3_reg <= rom_q_reg;
                default: ;
            endcase
        end
    end

    // Each coefficient is x*y*z plus or minus v*w scaled by one in Q15.
    always_comb
    begin
        op_x   = '0;
        op_y   = '0;
        op_z   = '0;
        op_v   = '0;
        op_w   = '0;
        op_neg = 1'b0;
        unique case (cnt_reg)
            4'd0:
            begin
                op_x = s2_reg; op_y = s3_reg; op_z = s1_reg;
                op_v = c1_reg; op_w = c3_reg;
            end
            4'd1:
            begin
                op_v = c2_reg; op_w = s3_reg;
            end
            4'd2:
            begin
                op_x = s2_reg; op_y = s3_reg; op_z = c1_reg;
                op_v = c3_reg; op_w = s1_reg; op_neg = 1'b1;
            end
            4'd3:
            begin
                op_x = s1_reg; op_y = c3_reg; op_z = s2_reg;
                op_v = c1_reg; op_w = s3_reg; op_neg = 1'b1;
            end
            4'd4:
            begin
                op_v = c2_reg; op_w = c3_reg;
            end
            4'd5:
            begin
                op_x = c1_reg; op_y = c3_reg; op_z = s2_reg;
                op_v = s1_reg; op_w = s3_reg;
            end
            4'd6:
            begin
                op_v = s1_reg; op_w = c2_reg;
            end
            4'd8:
            begin
                op_v = c1_reg; op_w = c2_reg;
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_v_reg <= 1'b0;
            b_v_reg <= 1'b0;
        end
        else
        begin
            a_v_reg <= (state_reg == ST_MULT) && (cnt_reg <= LAST_COEF);
            b_v_reg <= a_v_reg;
        end
    end

    always_comb
    begin
        if (b_neg_reg)
            coef_sum = b_t_reg - (triple_t'(b_d_reg) <<< COEF_FRAC_BITS);
        else
            coef_sum = b_t_reg + (triple_t'(b_d_reg) <<< COEF_FRAC_BITS);
        coef_rnd = (coef_sum + ROUND_HALF) >>> (2 * COEF_FRAC_BITS);
    end

    always_ff @(posedge clk)
    begin
        a_p1_reg  <= pair_t'(op_x) * pair_t'(op_y);
        a_p2_reg  <= pair_t'(op_v) * pair_t'(op_w);
        a_z_reg   <= op_z;
        a_neg_reg <= op_neg;
        a_idx_reg <= cnt_reg;

        b_t_reg   <= triple_t'(a_p1_reg) * triple_t'(a_z_reg);
        b_d_reg   <= a_p2_reg;
        b_neg_reg <= a_neg_reg;
        b_idx_reg <= a_idx_reg;

        if (b_v_reg)
        begin
            // The y column of the last row is the negated sine, unrounded.
            if (b_idx_reg == NEG_S2_IDX)
                coef_reg[b_idx_reg] <= -coef_t'(s2_reg);
            else
                coef_reg[b_idx_reg] <= coef_rnd[COEF_BITS-1:0];
        end
    end

    assign coef = coef_reg;
    assign busy = (state_reg != ST_IDLE);

    `ERP_ASSERT_NEXT(a_cfg_starts_update, cfg_we, busy,
                     "configuration write did not start a coefficient update")
    `ERP_ASSERT_SAME(a_write_in_mult, b_v_reg, state_reg == ST_MULT,
                     "coefficient written outside the multiply phase")

endmodule

@@ hdl/erp_datapath.sv @@
`include "euler_rotate_point_core_macros.svh"

module erp_datapath
    import erp_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      hold,
    input  coef_set_t coef,
    input  logic      in_valid,
    output logic      in_ready,
    input  coord_t    in_x,
    input  coord_t    in_y,
    input  coord_t    in_z,
    input  logic      in_last,
    output logic      out_valid,
    input  logic      out_ready,
    output coord_t    out_x,
    output coord_t    out_y,
    output coord_t    out_z,
    output logic      out_last
);

    localparam int PROD_BITS  = COORD_BITS + COEF_BITS;
    localparam int ACC_BITS   = PROD_BITS + 2;
    localparam int ROUND_BITS = ACC_BITS - COEF_FRAC_BITS;

    typedef logic signed [PROD_BITS-1:0]  prod_t;
    typedef logic signed [ACC_BITS-1:0]   acc_t;
    typedef logic signed [ROUND_BITS-1:0] round_t;

    localparam acc_t   ACC_HALF  = acc_t'(1) <<< (COEF_FRAC_BITS - 1);
    localparam coord_t COORD_MAX = {1'b0, {(COORD_BITS-1){1'b1}}};
    localparam coord_t COORD_MIN = {1'b1, {(COORD_BITS-1){1'b0}}};

    logic   st1_v_reg, st2_v_reg, st3_v_reg, out_valid_reg;
    logic   st1_rdy, st2_rdy, st3_rdy, out_rdy;
    coord_t st1_pt_reg [3];
    logic   st1_last_reg, st2_last_reg, st3_last_reg, out_last_reg;
    prod_t  st2_prod_reg [3][3];
    acc_t   st3_acc_reg [3];
    coord_t out_pt_reg [3];
    round_t rnd [3];
    coord_t sat [3];

    // Each stage moves on when it is empty or the stage after it moves.
    assign out_rdy  = !out_valid_reg || out_ready;
    assign st3_rdy  = !st3_v_reg || out_rdy;
    assign st2_rdy  = !st2_v_reg || st3_rdy;
    assign st1_rdy  = !st1_v_reg || st2_rdy;
    assign in_ready = st1_rdy && !hold;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st1_v_reg     <= 1'b0;
            st2_v_reg     <= 1'b0;
            st3_v_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (st1_rdy)
                st1_v_reg <= in_valid && in_ready;
            if (st2_rdy)
                st2_v_reg <= st1_v_reg;
            if (st3_rdy)
                st3_v_reg <= st2_v_reg;
            if (out_rdy)
                out_valid_reg <= st3_v_reg;
        end
    end

    always_comb
    begin
        for (int r = 0; r < 3; r++)
        begin
            rnd[r] = round_t'(st3_acc_reg[r] >>> COEF_FRAC_BITS);
            if (rnd[r] > round_t'(COORD_MAX))
                sat[r] = COORD_MAX;
            else if (rnd[r] < round_t'(COORD_MIN))
                sat[r] = COORD_MIN;
            else
                sat[r] = rnd[r][COORD_BITS-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (st1_rdy)
        begin
            st1_pt_reg[0] <= in_x;
            st1_pt_reg[1] <= in_y;
            st1_pt_reg[2] <= in_z;
            st1_last_reg  <= in_last;
        end
        if (st2_rdy)
        begin
            for (int r = 0; r < 3; r++)
            begin
                for (int c = 0; c < 3; c++)
                begin
                    st2_prod_reg[r][c] <= prod_t'(st1_pt_reg[c]) * prod_t'(coef[3*r + c]);
                end
            end
            st2_last_reg <= st1_last_reg;
        end
        if (st3_rdy)
        begin
            for (int r = 0; r < 3; r++)
            begin
                st3_acc_reg[r] <= acc_t'(st2_prod_reg[r][0]) + acc_t'(st2_prod_reg[r][1])
                                + acc_t'(st2_prod_reg[r][2]) + ACC_HALF;
            end
            st3_last_reg <= st2_last_reg;
        end
        if (out_rdy)
        begin
            out_pt_reg   <= sat;
            out_last_reg <= st3_last_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_x     = out_pt_reg[0];
    assign out_y     = out_pt_reg[1];
    assign out_z     = out_pt_reg[2];
    assign out_last  = out_last_reg;

    `ERP_ASSERT_NEXT(a_st1_holds, st1_v_reg && !st2_rdy,
                     st1_v_reg && $stable(st1_pt_reg[0]) && $stable(st1_last_reg),
                     "stalled point left the first stage")
    `ERP_ASSERT_SAME(a_out_from_pipe, $rose(out_valid_reg), $past(st3_v_reg),
                     "output became valid without a point in the sum stage")

endmodule

@@ dv/tb_euler_rotate_point_core.sv @@
module tb_euler_rotate_point_core;
    timeunit 1ns;
    timeprecision 1ps;

    import erp_pkg::*;

    // The run is cut short if it has not finished within this many clock cycles.
    localparam int LIMIT_CYCLES = 400000;

    // Stalls the receiver for this many cycles, so that the pipeline fills.
    localparam int LONG_HOLD_CYCLES = 300;

    // Points in each configured phase.
    localparam int PHASE_POINTS = 150;

    // An index that names no register; the block must ignore writes to it.
    localparam cfg_index_t CFG_UNUSED = 2'd3;

    // 2*pi in Q29, used to turn a fraction of a turn into radians.
    localparam longint unsigned TURN_RAD_Q29 = 64'd3373259426;

    localparam longint COORD_HI = (longint'(1) <<< (COORD_BITS - 1)) - 1;
    localparam longint COORD_LO = -COORD_HI - 1;
    localparam coord_t COORD_MAX = coord_t'(COORD_HI);
    localparam coord_t COORD_MIN = coord_t'(COORD_LO);

    typedef struct {
        coord_t x;
        coord_t y;
        coord_t z;
        logic   last;
    } point_t;

    typedef longint coef_mat_t [9];

    // DUT connections.  Every input starts at a known value.
    logic       clk       = 1'b0;
    logic       rst_n     = 1'b0;
    logic       cfg_valid = 1'b0;
    logic       cfg_ready;
    cfg_index_t cfg_index = CFG_ANGLE_X;
    angle_t     cfg_data  = '0;
    logic       in_valid  = 1'b0;
    logic       in_ready;
    coord_t     in_x      = '0;
    coord_t     in_y      = '0;
    coord_t     in_z      = '0;
    logic       in_last   = 1'b0;
    logic       out_valid;
    logic       out_ready = 1'b0;
    coord_t     out_x;
    coord_t     out_y;
    coord_t     out_z;
    logic       out_last;

    // Q1.15 sine and cosine of every angle code, built once at time zero.
    longint sin_q15 [ANGLE_STEPS];
    longint cos_q15 [ANGLE_STEPS];

    // The angles that the block should hold, updated on each register write.
    angle_t turn_x = '0;
    angle_t turn_y = '0;
    angle_t turn_z = '0;

    point_t point_q[$];      // points waiting to be offered to the block
    point_t rotated_q[$];    // rotated points expected, oldest first

    int queued_cnt   = 0;
    int accepted_cnt = 0;
    int mismatch_cnt = 0;
    int cycle_cnt    = 0;

    // Handshake flags, captured at each rising edge for the falling-edge drivers.
    logic pt_taken  = 1'b0;
    logic cfg_taken = 1'b0;

    // Random idling is switched off for the final phase of the run.
    bit lull_on = 1'b1;
    int send_gap = 0;
    int recv_gap = 0;

    // The stimulus asks for a long receiver stall by bumping hold_asked; the
    // receiver process counts the stall out itself.
    int hold_asked = 0;
    int hold_seen  = 0;
    int hold_left  = 0;

    euler_rotate_point_core u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_x      (in_x),
        .in_y      (in_y),
        .in_z      (in_z),
        .in_last   (in_last),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_x     (out_x),
        .out_y     (out_y),
        .out_z     (out_z),
        .out_last  (out_last)
    );

    initial
    begin
        forever
            #2 clk = ~clk;
    end

    // ------------------------------------------------------------------
    // Arithmetic of the rotator.
    // ------------------------------------------------------------------

    // Rounds a Q30 value to the nearest Q15 by magnitude, so that ties go
    // away from zero, and clamps a unit value to the largest Q1.15 code.
    function automatic longint q30_round_q15(longint v);
        longint mag;
        longint r;
        mag = (v < 0) ? -v : v;
        r = (mag + 64'sd16384) >>> 15;
        if (r > 64'sd32767)
            r = 64'sd32767;
        return (v < 0) ? -r : r;
    endfunction

    // Sine and cosine in Q30 of a Q30 radian angle within the first octant,
    // summed as Taylor series up to the 13th and 12th power.
    function automatic void octant_sincos(input longint unsigned a,
                                          output longint sn, output longint cs);
        longint unsigned a2;
        longint unsigned t;
        int n;
        a2 = (a * a) >> 30;
        t  = a;
        sn = longint'(a);
        for (n = 2; n <= 12; n += 2)
        begin
            t = ((t * a2) >> 30) / longint'(n * (n + 1));
            if ((n & 2) != 0)
                sn = sn - longint'(t);
            else
                sn = sn + longint'(t);
        end
        t  = 64'd1 << 30;
        cs = longint'(t);
        for (n = 1; n <= 11; n += 2)
        begin
            t = ((t * a2) >> 30) / longint'(n * (n + 1));
            if ((n & 2) != 0)
                cs = cs + longint'(t);
            else
                cs = cs - longint'(t);
        end
    endfunction

    // Fills the trig tables.  Each code is split into a quadrant and a
    // fraction of a quarter turn; the upper half of the quarter is folded
    // back, which swaps the roles of sine and cosine.
    function automatic void build_trig_tables();
        longint unsigned frac;
        longint unsigned rem;
        longint s;
        longint c;
        int unsigned quad;
        for (int k = 0; k < ANGLE_STEPS; k++)
        begin
            frac = (longint'(k) << 32) / ANGLE_STEPS;
            quad = 32'((frac >> 30) & 64'd3);
            rem  = frac & 64'h3FFF_FFFF;
            if (rem <= 64'h2000_0000)
                octant_sincos((rem * TURN_RAD_Q29) >> 31, s, c);
            else
                octant_sincos(((64'h4000_0000 - rem) * TURN_RAD_Q29) >> 31, c, s);
            case (quad)
                0:
                begin
                    sin_q15[k] = q30_round_q15(s);
                    cos_q15[k] = q30_round_q15(c);
                end
                1:
                begin
                    sin_q15[k] = q30_round_q15(c);
                    cos_q15[k] = q30_round_q15(-s);
                end
                2:
                begin
                    sin_q15[k] = q30_round_q15(-s);
                    cos_q15[k] = q30_round_q15(-c);
                end
                default:
                begin
                    sin_q15[k] = q30_round_q15(-c);
                    cos_q15[k] = q30_round_q15(s);
                end
            endcase
        end
    endfunction

    // Divides by 2^n, rounding to nearest with ties towards +infinity.
    function automatic longint round_div_pow2(longint v, int n);
        return (v + (longint'(1) <<< (n - 1))) >>> n;
    endfunction

    function automatic coord_t clamp_coord(longint v);
        if (v > COORD_HI)
            return COORD_MAX;
        if (v < COORD_LO)
            return COORD_MIN;
        return coord_t'(v);
    endfunction

    // The nine Q2.15 coefficients of the rotation.  The triple products are
    // in Q45 and the double ones are lifted to Q45 before rounding.
    function automatic coef_mat_t build_matrix(angle_t ax, angle_t ay, angle_t az);
        coef_mat_t m;
        longint s1;
        longint c1;
        longint s2;
        longint c2;
        longint s3;
        longint c3;
        longint unit;
        unit = 64'sd32768;
        s1 = sin_q15[ax % ANGLE_STEPS];
        c1 = cos_q15[ax % ANGLE_STEPS];
        s2 = sin_q15[ay % ANGLE_STEPS];
        c2 = cos_q15[ay % ANGLE_STEPS];
        s3 = sin_q15[az % ANGLE_STEPS];
        c3 = cos_q15[az % ANGLE_STEPS];
        m[0] = round_div_pow2(s1 * s2 * s3 + c1 * c3 * unit, 30);
        m[1] = round_div_pow2(c2 * s3 * unit, 30);
        m[2] = round_div_pow2(c1 * s2 * s3 - c3 * s1 * unit, 30);
        m[3] = round_div_pow2(c3 * s1 * s2 - c1 * s3 * unit, 30);
        m[4] = round_div_pow2(c2 * c3 * unit, 30);
        m[5] = round_div_pow2(c1 * c3 * s2 + s1 * s3 * unit, 30);
        m[6] = round_div_pow2(s1 * c2 * unit, 30);
        m[7] = -s2;
        m[8] = round_div_pow2(c1 * c2 * unit, 30);
        return m;
    endfunction

    function automatic point_t rotate_point(point_t p, coef_mat_t m);
        point_t r;
        longint acc [3];
        for (int i = 0; i < 3; i++)
            acc[i] = longint'(p.x) * m[3 * i] + longint'(p.y) * m[3 * i + 1]
                   + longint'(p.z) * m[3 * i + 2];
        r.x    = clamp_coord(round_div_pow2(acc[0], 15));
        r.y    = clamp_coord(round_div_pow2(acc[1], 15));
        r.z    = clamp_coord(round_div_pow2(acc[2], 15));
        r.last = p.last;
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Point driver.  It changes the input word only at falling edges, and
    // holds the word until the rising edge at which it is taken.
    // ------------------------------------------------------------------
    always @(negedge clk)
    begin : drive_points
        point_t nxt;
        if (!in_valid || pt_taken)
        begin
            if (send_gap == 0 && lull_on && point_q.size() > 0 && $urandom_range(0, 7) == 0)
                send_gap = $urandom_range(1, 11);
            if (send_gap > 0)
            begin
                send_gap--;
                in_valid <= 1'b0;
            end
            else if (point_q.size() > 0)
            begin
                nxt = point_q.pop_front();
                in_x     <= nxt.x;
                in_y     <= nxt.y;
                in_z     <= nxt.z;
                in_last  <= nxt.last;
                in_valid <= 1'b1;
            end
            else
                in_valid <= 1'b0;
        end
    end

    // ------------------------------------------------------------------
    // Receiver.  Random stalls, plus the long stall that the stimulus asks for
    // while the sender keeps offering points.
    // ------------------------------------------------------------------
    always @(negedge clk)
    begin : drive_ready
        if (hold_seen != hold_asked)
        begin
            hold_seen = hold_asked;
            hold_left = LONG_HOLD_CYCLES;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            out_ready <= 1'b0;
        end
        else if (recv_gap > 0)
        begin
            recv_gap--;
            out_ready <= 1'b0;
        end
        else if (lull_on && $urandom_range(0, 9) == 0)
        begin
            recv_gap = $urandom_range(0, 10);
            out_ready <= 1'b0;
        end
        else
            out_ready <= 1'b1;
    end

    task automatic compare_field(string what, coord_t want, coord_t got);
        if (got !== want)
        begin
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, what, want, got);
            mismatch_cnt++;
        end
    endtask

    // ------------------------------------------------------------------
    // Monitor and predictor, sampling every handshake at the rising edge.
    // A result word is checked against the oldest expectation; a point word
    // that is taken queues its rotated image; a register write updates the
    // angles that later points are rotated by.
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin : watch_words
        point_t want;
        point_t pt;
        pt_taken  <= in_valid && in_ready;
        cfg_taken <= cfg_valid && cfg_ready;
        if (rst_n)
        begin
            if (out_valid && out_ready)
            begin
                if (rotated_q.size() == 0)
                begin
                    $display("%0t: result word with no point outstanding, %s (%0d, %0d, %0d) last %0b",
                             $time, "got", out_x, out_y, out_z, out_last);
                    mismatch_cnt++;
                end
                else
                begin
                    want = rotated_q.pop_front();
                    compare_field("out_x", want.x, out_x);
                    compare_field("out_y", want.y, out_y);
                    compare_field("out_z", want.z, out_z);
                    compare_field("out_last", coord_t'(want.last), coord_t'(out_last));
                end
            end
            if (in_valid && in_ready)
            begin
                pt.x    = in_x;
                pt.y    = in_y;
                pt.z    = in_z;
                pt.last = in_last;
                rotated_q.push_back(rotate_point(pt, build_matrix(turn_x, turn_y, turn_z)));
                accepted_cnt++;
            end
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    CFG_ANGLE_X: turn_x = cfg_data;
                    CFG_ANGLE_Y: turn_y = cfg_data;
                    CFG_ANGLE_Z: turn_z = cfg_data;
                    default:     ;
                endcase
            end
        end
    end

    // Watchdog: a run that hangs is reported as a failure.
    always @(posedge clk)
    begin
        cycle_cnt++;
        if (cycle_cnt > LIMIT_CYCLES)
        begin
            $display("%0t: run did not finish within %0d cycles", $time, LIMIT_CYCLES);
            $display("Some tests failed");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus.
    // ------------------------------------------------------------------

    // Register writes drive the channel at falling edges and wait for the
    // handshake; the block refuses them while it rebuilds its matrix.
    task automatic write_reg(cfg_index_t idx, angle_t value);
        @(negedge clk);
        cfg_valid = 1'b1;
        cfg_index = idx;
        cfg_data  = value;
        do
            @(negedge clk);
        while (!cfg_taken);
        cfg_valid = 1'b0;
    endtask

    task automatic set_angles(angle_t ax, angle_t ay, angle_t az);
        write_reg(CFG_ANGLE_X, ax);
        write_reg(CFG_ANGLE_Y, ay);
        write_reg(CFG_ANGLE_Z, az);
    endtask

    // Waits until every point has been taken and every result has come back,
    // then lets the pipeline drain a little further.
    task automatic wait_idle();
        @(negedge clk);
        while (accepted_cnt != queued_cnt || rotated_q.size() != 0)
            @(negedge clk);
        repeat (8) @(negedge clk);
    endtask

    function automatic void queue_point(coord_t x, coord_t y, coord_t z, logic last);
        point_t p;
        p.x    = x;
        p.y    = y;
        p.z    = z;
        p.last = last;
        point_q.push_back(p);
        queued_cnt++;
    endfunction

    // Corners of the coordinate range, unit vectors, and values close to
    // zero where the final rounding decides the result.
    task automatic queue_directed();
        @(posedge clk);
        queue_point(coord_t'(0), coord_t'(0), coord_t'(0), 1'b0);
        queue_point(COORD_MAX, COORD_MAX, COORD_MAX, 1'b1);
        queue_point(COORD_MIN, COORD_MIN, COORD_MIN, 1'b0);
        queue_point(COORD_MAX, COORD_MIN, COORD_MAX, 1'b0);
        queue_point(COORD_MIN, COORD_MAX, COORD_MIN, 1'b1);
        queue_point(coord_t'(1), coord_t'(-1), coord_t'(1), 1'b0);
        queue_point(coord_t'(-1), coord_t'(-1), coord_t'(-1), 1'b0);
        queue_point(coord_t'(256), coord_t'(0), coord_t'(0), 1'b0);
        queue_point(coord_t'(0), coord_t'(256), coord_t'(0), 1'b0);
        queue_point(coord_t'(0), coord_t'(0), coord_t'(256), 1'b1);
        queue_point(coord_t'(128), coord_t'(-128), coord_t'(127), 1'b0);
        queue_point(COORD_MAX, coord_t'(0), COORD_MIN, 1'b1);
    endtask

    // Mostly full-range values, with extremes and small values mixed in so
    // that both saturation and fine rounding are reached often.
    function automatic coord_t pick_coord();
        case ($urandom_range(0, 11))
            0:       return COORD_MAX;
            1:       return COORD_MIN;
            2:       return coord_t'(int'($urandom_range(0, 8191)) - 4096);
            3:       return coord_t'(int'($urandom_range(0, 15)) - 8);
            default: return coord_t'($urandom());
        endcase
    endfunction

    task automatic run_phase(angle_t ax, angle_t ay, angle_t az, bit long_stall);
        set_angles(ax, ay, az);
        @(posedge clk);
        for (int i = 0; i < PHASE_POINTS; i++)
            queue_point(pick_coord(), pick_coord(), pick_coord(), $urandom_range(0, 7) == 0);
        if (long_stall)
            hold_asked++;
        wait_idle();
    endtask

    initial
    begin
        build_trig_tables();
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // With the reset angles the matrix is close to the identity.
        queue_directed();
        wait_idle();

        // The same corners under a skewed rotation, where they saturate.
        set_angles(10'd128, 10'd384, 10'd896);
        queue_directed();
        wait_idle();

        run_phase(10'd1023, 10'd1023, 10'd1023, 1'b0);
        // Quarter turns give unit sines, held as the largest Q1.15 value.
        // The receiver stalls at length here so that the input backs up.
        run_phase(10'd256, 10'd0, 10'd0, 1'b1);
        run_phase(10'd0, 10'd256, 10'd0, 1'b0);
        // A write to an index beyond the register list must change nothing.
        write_reg(CFG_UNUSED, angle_t'($urandom_range(0, 1023)));
        run_phase(10'd0, 10'd0, 10'd256, 1'b0);
        run_phase(10'd512, 10'd512, 10'd512, 1'b0);
        run_phase(10'd768, 10'd640, 10'd384, 1'b0);
        for (int n = 0; n < 5; n++)
            run_phase(angle_t'($urandom_range(0, 1023)), angle_t'($urandom_range(0, 1023)),
                      angle_t'($urandom_range(0, 1023)), 1'b0);

        // The final phase runs at full rate with no idling on either side.
        @(posedge clk);
        lull_on = 1'b0;
        run_phase(angle_t'($urandom_range(0, 1023)), angle_t'($urandom_range(0, 1023)),
                  angle_t'($urandom_range(0, 1023)), 1'b0);

        // A little longer than the pipeline depth, to catch stray words.
        repeat (12) @(negedge clk);
        if (mismatch_cnt == 0 && rotated_q.size() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
